@@ hw/rtl/rtd_pkg.sv @@
// ----------------------------------------------------------------------------
// rtd_pkg: shared types and constants of the RLE tile decoder
// Holds the stream word layouts, the parser and drain state encodings and
// the entry format of the command queue between the front and back parts.
// ----------------------------------------------------------------------------
package rtd_pkg;

  // Stream word widths
  localparam int S_TDATA_W = 24;  // table_address, value, tile_mode
  localparam int S_TUSER_W = 2;   // operation, tile_start
  localparam int M_TDATA_W = 48;  // pixels, pixel_count, start_position, pad

  // Input operation codes
  localparam logic OP_LUT_WRITE = 1'b0;
  localparam logic OP_STREAM    = 1'b1;

  // Count byte split point and raw 8bpp mode code
  localparam logic [7:0] RAW_MODE   = 8'h80;
  localparam logic [7:0] COUNT_SPLIT = 8'h80;

  // Command queue between the parts
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_LITERAL,
    PH_VALUE
  } parser_phase_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  // One parsed stream byte: repeat pix0 (raw) or the pair pix0,pix1 reps times
  typedef struct packed {
    logic       start;
    logic       raw;
    logic [7:0] reps;
    logic [7:0] pix0;
    logic [7:0] pix1;
  } q_entry_t;

endpackage

@@ hw/rtl/rtd_front.sv @@
// ----------------------------------------------------------------------------
// rtd_front: input parser of the RLE tile decoder
// Accepts stream words, keeps the lookup table, tracks count / literal /
// value phases and turns each tile byte into a queue command.
// ----------------------------------------------------------------------------
module rtd_front #(
  parameter int NUM_TABLES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rtd_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [rtd_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          push,
  output rtd_pkg::q_entry_t             entry,
  input  logic                          q_full
);
  import rtd_pkg::*;

  logic [7:0]    lut [256];
  logic [7:0]    rd_lo;
  logic [7:0]    rd_hi;

  logic          op;
  logic          start;
  logic [7:0]    addr;
  logic [7:0]    byte_in;
  logic [7:0]    mode;
  logic          accept;
  logic [3:0]    tbl;
  logic [7:0]    addr_lo;
  logic [7:0]    addr_hi;

  parser_phase_t phase;
  parser_phase_t phase_next;
  logic [7:0]    run;
  logic [7:0]    run_next;
  logic [7:0]    reps_next;

  logic          hold_valid;
  logic          hold_start;
  logic          hold_raw;
  logic [7:0]    hold_reps;
  logic [7:0]    hold_byte;

  // Table number of each mode value as a constant lookup; only the low four
  // bits reach the address since table * 16 + nibble wraps to 8 bits
  function automatic logic [3:0] table_of(input logic [7:0] m);
    logic [3:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      if (m == 8'(i)) begin
        t = 4'(i % NUM_TABLES);
      end
    end
    return t;
  endfunction

  assign op      = s_tuser[0];
  assign start   = s_tuser[1];
  assign addr    = s_tdata[7:0];
  assign byte_in = s_tdata[15:8];
  assign mode    = s_tdata[23:16];

  assign push     = hold_valid && !q_full;
  assign s_tready = !hold_valid || !q_full;
  assign accept   = s_tvalid && s_tready;

  assign tbl     = table_of(mode);
  assign addr_lo = {tbl, byte_in[3:0]};
  assign addr_hi = {tbl, byte_in[7:4]};

  // Parser phase for a stream byte; tile start restarts before parsing
  always_comb begin
    parser_phase_t ph;
    logic [7:0]    rn;
    ph = start ? PH_COUNT : phase;
    rn = start ? 8'd0 : run;
    phase_next = phase;
    run_next   = run;
    reps_next  = 8'd0;
    case (ph)
      PH_LITERAL: begin
        run_next   = rn - 8'd1;
        phase_next = (run_next == 8'd0) ? PH_COUNT : PH_LITERAL;
        reps_next  = 8'd1;
      end
      PH_VALUE: begin
        phase_next = PH_COUNT;
        run_next   = 8'd0;
        reps_next  = rn;
      end
      default: begin
        if (byte_in > COUNT_SPLIT) begin
          run_next   = byte_in - COUNT_SPLIT;
          phase_next = PH_LITERAL;
        end else begin
          run_next   = byte_in;
          phase_next = PH_VALUE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_LUT_WRITE) begin
      lut[addr] <= byte_in;
    end
    if (accept && op == OP_STREAM) begin
      rd_lo <= lut[addr_lo];
      rd_hi <= lut[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_COUNT;
      run        <= 8'd0;
      hold_valid <= 1'b0;
    end else begin
      if (accept && op == OP_STREAM) begin
        phase      <= phase_next;
        run        <= run_next;
        hold_valid <= 1'b1;
      end else if (push) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_STREAM) begin
      hold_start <= start;
      hold_raw   <= (mode == RAW_MODE);
      hold_reps  <= reps_next;
      hold_byte  <= byte_in;
    end
  end

  always_comb begin
    entry.start = hold_start;
    entry.raw   = hold_raw;
    entry.reps  = hold_reps;
    entry.pix0  = hold_raw ? hold_byte : rd_lo;
    entry.pix1  = rd_hi;
  end

endmodule

@@ hw/rtl/rtd_queue.sv @@
// ----------------------------------------------------------------------------
// rtd_queue: command queue of the RLE tile decoder
// Short register FIFO that decouples the parser from the pixel drain.
// ----------------------------------------------------------------------------
module rtd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rtd_pkg::q_entry_t entry_in,
  output logic              full,
  input  logic              pop,
  output rtd_pkg::q_entry_t entry_out,
  output logic              empty
);
  import rtd_pkg::*;

  q_entry_t       slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full      = (fill == (QAW+1)'(QDEPTH));
  assign empty     = (fill == '0);
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue push while full");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QAW+1)'(QDEPTH))
    else $error("queue fill out of range");

endmodule

@@ hw/rtl/rtd_back.sv @@
// ----------------------------------------------------------------------------
// rtd_back: pixel drain of the RLE tile decoder
// Pops queue commands, clips runs to the tile, groups pixels into output
// words and tracks the tile pixel position.
// ----------------------------------------------------------------------------
module rtd_back #(
  parameter int TILE_PIXELS       = 256,
  parameter int PIXELS_PER_RESULT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          pop,
  input  rtd_pkg::q_entry_t             entry,
  input  logic                          q_empty,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rtd_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import rtd_pkg::*;

  localparam int PW    = $clog2(TILE_PIXELS + 1);
  localparam int NW    = (PW > 9) ? PW : 9;
  localparam int CW    = $clog2(PIXELS_PER_RESULT + 1);
  localparam int LANES = (PIXELS_PER_RESULT < 4) ? PIXELS_PER_RESULT : 4;

  back_state_t state;
  back_state_t state_next;

  logic [PW-1:0] pos;
  logic [NW-1:0] rem;
  logic          par;
  logic          raw;
  logic [7:0]    pix0;
  logic [7:0]    pix1;

  logic [PW-1:0] pos_eff;
  logic [NW-1:0] run_len;
  logic [NW-1:0] room;
  logic [NW-1:0] clipped;
  logic          out_free;
  logic          emit;
  logic [CW-1:0] cnt;
  logic          last_word;
  logic [31:0]   word;

  logic [31:0]   out_pixels;
  logic [2:0]    out_count;
  logic [7:0]    out_start;

  assign out_free = !m_tvalid || m_tready;

  // Clip the popped run against what is left of the tile
  always_comb begin
    pos_eff = entry.start ? '0 : pos;
    run_len = entry.raw ? NW'(entry.reps) : NW'({entry.reps, 1'b0});
    room    = (NW'(pos_eff) >= NW'(TILE_PIXELS)) ? '0
              : NW'(TILE_PIXELS) - NW'(pos_eff);
    clipped = (run_len < room) ? run_len : room;
  end

  // Current group
  always_comb begin
    cnt       = (rem < NW'(PIXELS_PER_RESULT)) ? CW'(rem) : CW'(PIXELS_PER_RESULT);
    last_word = (rem <= NW'(PIXELS_PER_RESULT));
    word      = '0;
    for (int j = 0; j < LANES; j++) begin
      if (CW'(j) < cnt) begin
        word[8*j +: 8] = (!raw && (par ^ j[0])) ? pix1 : pix0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty && clipped != '0) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && last_word) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    case (state)
      BK_IDLE: pop  = !q_empty;
      BK_EMIT: emit = out_free;
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      pos      <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        pos <= pos_eff;
        rem <= clipped;
      end else if (emit) begin
        pos <= pos + PW'(cnt);
        rem <= rem - NW'(cnt);
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      raw  <= entry.raw;
      pix0 <= entry.pix0;
      pix1 <= entry.pix1;
      par  <= 1'b0;
    end else if (emit) begin
      par <= par ^ PIXELS_PER_RESULT[0];
    end
    if (emit) begin
      out_pixels <= word;
      out_count  <= 3'(cnt);
      out_start  <= 8'(pos);
      m_tlast    <= last_word;
    end
  end

  assign m_tdata = {(M_TDATA_W-43)'(0), out_start, out_count, out_pixels};

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT) |-> (rem != '0))
    else $error("drain active with nothing left");

  a_pos_in_tile: assert property (@(posedge clk) disable iff (rst)
    NW'(pos) <= NW'(TILE_PIXELS))
    else $error("pixel position beyond tile");

  a_run_drains: assert property (@(posedge clk) disable iff (rst)
    (emit && last_word) |=> (rem == '0))
    else $error("run not fully drained on last word");

endmodule

@@ hw/rtl/rle_tile_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_tile_decoder: run-length decoder for 16x16 tile pixel streams
// Parser front, command queue and pixel drain back end.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one word per compressed byte or lookup write.
//     tuser[0] = 0 writes value into lookup entry table_address; 1 feeds a
//     tile byte. tuser[1] marks the first byte of a tile and restarts the
//     parser and the pixel position. Lookup entries must be written before
//     a 4bpp tile reads them.
//   Master stream (m_*): words of up to PIXELS_PER_RESULT pixels with their
//     pixel count and tile start position; tlast flags the final word that
//     one input byte produced. Bytes that give no pixels give no word.
//   Flow: the drain pops a command while idle, then emits its output words
//     and waits while the receiver stalls; the parser takes one word per
//     cycle into a 4-entry queue and stalls only when that queue fills.
//   Reset: rst clears the parser, queue, drain and position; lookup
//     contents are kept undefined until written.
//   Stall: a held master word keeps its value; the drain waits and the
//     queue then backs pressure up to s_tready.
// ----------------------------------------------------------------------------
module rle_tile_decoder #(
  parameter int NUM_TABLES        = 16,
  parameter int TILE_PIXELS       = 256,
  parameter int PIXELS_PER_RESULT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] table_address, [15:8] value, [23:16] tile_mode
  input  logic [rtd_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] operation, [1] tile_start
  input  logic [rtd_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] pixels, [34:32] pixel_count, [42:35] start_position, [47:43] zero
  output logic [rtd_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import rtd_pkg::*;

  q_entry_t push_entry;
  q_entry_t pop_entry;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  // Parse bytes and own the lookup table
  rtd_front #(
    .NUM_TABLES(NUM_TABLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .entry    (push_entry),
    .q_full   (q_full)
  );

  // Decouple parsing from draining
  rtd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (push_entry),
    .full      (q_full),
    .pop       (pop),
    .entry_out (pop_entry),
    .empty     (q_empty)
  );

  // Clip, group and emit pixels
  rtd_back #(
    .TILE_PIXELS       (TILE_PIXELS),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .entry    (pop_entry),
    .q_empty  (q_empty),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ verif/tb_rle_tile_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_rle_tile_decoder: self-checking bench for the RLE tile decoder
// Drives lookup writes and compressed tile bytes with random stalls on both
// stream sides. A scoreboard predicts every pixel group and checks each
// accepted output word against the oldest group it still expects.
// ----------------------------------------------------------------------------
module tb_rle_tile_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import rtd_pkg::*;

  localparam int NUM_TABLES        = 16;
  localparam int TILE_PIXELS       = 256;
  localparam int PIXELS_PER_RESULT = 4;
  localparam int RANDOM_ITEMS      = 215;
  localparam int HOLD_CYCLES       = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT    = 4000;  // cycles with no word moving
  localparam int IDLE_PERCENT      = 18;

  // One pixel group as it leaves the master stream
  typedef struct packed {
    logic [31:0] pixels;
    logic [2:0]  count;
    logic [7:0]  position;
    logic        last;
  } pix_group_t;

  // Predicts the pixel groups of each accepted word and checks the output.
  class tile_pixel_scoreboard;
    logic [7:0]    lut [256];
    logic [7:0]    run_px [256];
    parser_phase_t phase;
    logic [7:0]    run_left;
    int            position;
    pix_group_t    groups_due [$];
    int unsigned   errors;
    int unsigned   groups_checked;

    function new();
      phase          = PH_COUNT;
      run_left       = 8'h00;
      position       = 0;
      errors         = 0;
      groups_checked = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // 8bpp passes the byte through; 4bpp gives two lookups, low nibble first
    function void decode_byte(logic [7:0] mode, logic [7:0] b,
                              output logic [7:0] p0, output logic [7:0] p1,
                              output int per);
      int tbl;
      tbl = mode % NUM_TABLES;
      if (mode == RAW_MODE) begin
        p0  = b;
        p1  = 8'h00;
        per = 1;
      end else begin
        p0  = lut[8'(tbl * 16 + b[3:0])];
        p1  = lut[8'(tbl * 16 + b[7:4])];
        per = 2;
      end
    endfunction

    // Place n pixels at the current position, drop what overflows the tile
    function void emit_pixels(int n);
      int          room;
      int          cnt;
      logic [31:0] word;
      pix_group_t  g;
      if (position >= TILE_PIXELS) return;
      room = TILE_PIXELS - position;
      if (n > room) n = room;
      for (int i = 0; i < n; i += PIXELS_PER_RESULT) begin
        cnt  = (n - i > PIXELS_PER_RESULT) ? PIXELS_PER_RESULT : n - i;
        word = 32'h0;
        for (int j = 0; j < cnt; j++) word[8*j +: 8] = run_px[i + j];
        g.pixels   = word;
        g.count    = 3'(cnt);
        g.position = 8'(position + i);
        g.last     = (i + cnt >= n);
        groups_due.push_back(g);
      end
      position += n;
    endfunction

    function void note_word(logic op, logic [7:0] addr, logic [7:0] val,
                            logic [7:0] mode, logic start);
      logic [7:0] p0;
      logic [7:0] p1;
      int         per;
      int         n;
      if (op == OP_LUT_WRITE) begin
        lut[addr] = val;
        return;
      end
      if (start) begin
        phase    = PH_COUNT;
        run_left = 8'h00;
        position = 0;
      end
      case (phase)
        PH_LITERAL: begin
          run_left = run_left - 8'd1;
          if (run_left == 8'h00) phase = PH_COUNT;
          decode_byte(mode, val, p0, p1, per);
          run_px[0] = p0;
          run_px[1] = p1;
          emit_pixels(per);
        end
        PH_VALUE: begin
          decode_byte(mode, val, p0, p1, per);
          n = 0;
          for (int r = 0; r < run_left && n + per <= 256; r++) begin
            run_px[n] = p0;
            if (per == 2) run_px[n + 1] = p1;
            n += per;
          end
          phase    = PH_COUNT;
          run_left = 8'h00;
          emit_pixels(n);
        end
        default: begin
          if (val > COUNT_SPLIT) begin
            run_left = val - COUNT_SPLIT;
            phase    = PH_LITERAL;
          end else begin
            run_left = val;
            phase    = PH_VALUE;
          end
        end
      endcase
    endfunction

    task check_word(logic [31:0] px, logic [2:0] cnt, logic [7:0] pos, logic last);
      pix_group_t want;
      groups_checked++;
      if (groups_due.size() == 0) begin
        report_mismatch($sformatf("group with nothing due: pixels %h count %0d pos %0d",
                                  px, cnt, pos));
        return;
      end
      want = groups_due.pop_front();
      if (px !== want.pixels)
        report_mismatch($sformatf("pos %0d pixels %h, want %h", want.position, px,
                                  want.pixels));
      if (cnt !== want.count)
        report_mismatch($sformatf("pos %0d count %0d, want %0d", want.position, cnt,
                                  want.count));
      if (pos !== want.position)
        report_mismatch($sformatf("start position %0d, want %0d", pos, want.position));
      if (last !== want.last)
        report_mismatch($sformatf("pos %0d last %b, want %b", want.position, last,
                                  want.last));
    endtask

    task flag_leftovers();
      if (groups_due.size() != 0)
        report_mismatch($sformatf("%0d pixel groups never arrived", groups_due.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // [7:0] table_address, [15:8] value, [23:16] tile_mode
  logic [S_TUSER_W-1:0]  s_tuser;   // [0] operation, [1] tile_start
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // [31:0] pixels, [34:32] pixel_count, [42:35] start_position
  logic                  m_tlast;

  tile_pixel_scoreboard sb;

  bit          s_took;         // input word accepted at the last rising edge
  bit          steady_run;     // no idling on either side while set
  bit          hold_request;   // ask the receiver for one long hold-off
  bit          lut_written [256];
  int unsigned items_sent;
  int unsigned lut_writes;
  int unsigned tiles_sent;

  rle_tile_decoder #(
    .NUM_TABLES        (NUM_TABLES),
    .TILE_PIXELS       (TILE_PIXELS),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both handshakes at the rising edge; DUT updates land after this.
  always @(posedge clk) begin
    s_took = !rst && s_tvalid && s_tready;
    if (s_took)
      sb.note_word(s_tuser[0], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser[1]);
    if (!rst && m_tvalid && m_tready)
      sb.check_word(m_tdata[31:0], m_tdata[34:32], m_tdata[42:35], m_tlast);
  end

  // End the run if no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request. Outside a
  // hold-off each pass sets m_tready once and moves to the next falling edge.
  initial begin : receiver
    int held;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        m_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
        @(negedge clk);
      end
    end
  end

  function automatic bit table_ready(logic [3:0] t);
    for (int i = 0; i < 16; i++)
      if (!lut_written[{t, 4'(i)}]) return 1'b0;
    return 1'b1;
  endfunction

  // Pick a tile mode whose lookup table is fully written (or raw 8bpp).
  // Table 0 is loaded up front, so the search always ends.
  function automatic logic [7:0] pick_mode();
    logic [3:0] t;
    if ($urandom_range(0, 3) == 0) return RAW_MODE;
    t = 4'($urandom_range(0, NUM_TABLES - 1));
    while (!table_ready(t)) t = t + 4'd1;
    return {4'($urandom_range(0, 15)), t};
  endfunction

  // Offer one word at a falling edge and hold it until it is taken.
  // Entered and left at a falling edge.
  task automatic send_word(input logic op, input logic [7:0] addr, input logic [7:0] val,
                           input logic [7:0] mode, input logic start);
    while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {mode, val, addr};
    s_tuser  <= {start, op};
    do @(negedge clk); while (!s_took);
    items_sent++;
    if (op == OP_LUT_WRITE) begin
      lut_written[addr] = 1'b1;
      lut_writes++;
    end else if (start) begin
      tiles_sent++;
    end
  endtask

  // Stream byte; the table address field is don't-care here, so randomize it.
  task automatic stream_byte(input logic [7:0] val, input logic [7:0] mode,
                             input logic start);
    send_word(OP_STREAM, 8'($urandom), val, mode, start);
  endtask

  // Lookup write; mode and tile_start are ignored, so randomize them.
  task automatic lut_write(input logic [7:0] addr, input logic [7:0] val);
    send_word(OP_LUT_WRITE, addr, val, 8'($urandom), 1'($urandom));
  endtask

  task automatic load_table(input logic [3:0] t);
    for (int i = 0; i < 16; i++) lut_write({t, 4'(i)}, 8'($urandom));
  endtask

  // One tile: a few literal or repeat runs with random content. Now and then
  // cut a run short so the next tile start lands mid-run.
  task automatic one_tile();
    logic [7:0] mode;
    logic [7:0] cnt;
    bit         first;
    int         runs;
    int         len;
    int         cut;
    mode  = pick_mode();
    first = 1'b1;
    runs  = $urandom_range(1, 6);
    for (int r = 0; r < runs; r++) begin
      if ($urandom_range(0, 9) == 0) mode = pick_mode();
      if ($urandom_range(0, 1) == 1) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        stream_byte(8'(COUNT_SPLIT + len), mode, first);
        first = 1'b0;
        cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++)
          stream_byte(8'($urandom), ($urandom_range(0, 15) == 0) ? pick_mode() : mode, 1'b0);
        if (cut != len) return;
      end else begin
        case ($urandom_range(0, 7))
          0:       cnt = 8'h00;
          1:       cnt = COUNT_SPLIT;
          default: cnt = 8'($urandom_range(1, 127));
        endcase
        stream_byte(cnt, mode, first);
        first = 1'b0;
        if ($urandom_range(0, 12) == 0) return;   // drop the value byte
        stream_byte(8'($urandom), mode, 1'b0);
      end
    end
  endtask

  // Full 4bpp repeat runs, one tile each, while the receiver holds off:
  // the queue fills and s_tready has to drop.
  task automatic pressure_burst();
    hold_request = 1'b1;
    for (int k = 0; k < 6; k++) begin
      stream_byte(COUNT_SPLIT, 8'h00, 1'b1);
      stream_byte(8'($urandom), 8'h00, 1'b0);
    end
  endtask

  initial begin : stimulus
    int unsigned random_base;
    int          pick;
    bit          pressed;
    sb           = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    steady_run   = 1'b0;
    hold_request = 1'b0;
    items_sent   = 0;
    lut_writes   = 0;
    tiles_sent   = 0;
    pressed      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Table 0 with both extreme entry values
    for (int i = 0; i < 16; i++)
      lut_write(8'(i), (i == 0) ? 8'h00 : (i == 15) ? 8'hff : 8'($urandom));

    // single literal byte, raw
    stream_byte(8'h81, RAW_MODE, 1'b1);
    stream_byte(8'hff, RAW_MODE, 1'b0);
    // zero repeat count: value byte eaten, no pixels
    stream_byte(8'h00, RAW_MODE, 1'b0);
    stream_byte(8'h5a, RAW_MODE, 1'b0);
    // short 4bpp repeat through table 0 with high mode bits set
    stream_byte(8'h02, 8'hf0, 1'b0);
    stream_byte(8'hf0, 8'hf0, 1'b0);
    // longest repeat in 4bpp overruns the tile
    stream_byte(COUNT_SPLIT, 8'h00, 1'b0);
    stream_byte(8'h3c, 8'h00, 1'b0);
    // tile is full: literal byte parsed but dropped
    stream_byte(8'h81, RAW_MODE, 1'b0);
    stream_byte(8'h11, RAW_MODE, 1'b0);
    // longest literal, cut by a new tile start
    stream_byte(8'hff, RAW_MODE, 1'b1);
    stream_byte(8'h00, RAW_MODE, 1'b0);
    stream_byte(8'h7f, RAW_MODE, 1'b0);
    stream_byte(8'h03, 8'h90, 1'b1);
    stream_byte(8'h80, 8'h90, 1'b0);
    // longest raw repeat
    stream_byte(COUNT_SPLIT, RAW_MODE, 1'b0);
    stream_byte(8'h01, RAW_MODE, 1'b0);

    // Random part: mostly well-formed tiles, some table loads and stray writes
    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      steady_run = (items_sent - random_base >= 150) && (items_sent - random_base < 210);
      if (!pressed && items_sent - random_base >= 90) begin
        pressed = 1'b1;
        pressure_burst();
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) load_table(4'($urandom_range(0, NUM_TABLES - 1)));
      else if (pick < 15) lut_write(8'($urandom), 8'($urandom));
      else one_tile();
    end
    steady_run = 1'b0;
    s_tvalid <= 1'b0;

    // Drain: wait for every due group, then keep watching for strays
    while (sb.groups_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    sb.flag_leftovers();

    $display("Covered %0d input words (%0d lookup writes, %0d tiles), %0d pixel groups checked",
             items_sent, lut_writes, tiles_sent, sb.groups_checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rtd_pkg.sv
hw/rtl/rtd_front.sv
hw/rtl/rtd_queue.sv
hw/rtl/rtd_back.sv
hw/rtl/rle_tile_decoder.sv
verif/tb_rle_tile_decoder.sv
